>>> rtl/pstq_pkg.sv
`default_nettype none

package pstq_pkg;

    localparam int QueueDepthDefault = 16;

    localparam int IdW   = 8;
    localparam int PrioW = 8;
    localparam int CmdW  = 2;
    localparam int CntW  = 5;

    localparam logic [CmdW-1:0] CMD_INSERT = 2'd0;
    localparam logic [CmdW-1:0] CMD_REMOVE = 2'd1;
    localparam logic [CmdW-1:0] CMD_LOOKUP = 2'd2;

    // one queue slot
    typedef struct packed {
        logic             valid;
        logic [IdW-1:0]   id;
        logic [PrioW-1:0] prio;
    } entry_t;

    // broadcast to every cell
    typedef struct packed {
        logic             cmp_en;
        logic             do_ins;
        logic             do_rem;
        logic [IdW-1:0]   id;
        logic [PrioW-1:0] prio;
    } cell_ctl_t;

endpackage

`default_nettype wire

>>> rtl/pstq_cell.sv
`default_nettype none

module pstq_cell (
    input  wire                      clk,
    input  wire                      rst_n,
    input  wire pstq_pkg::cell_ctl_t ctl,
    input  wire pstq_pkg::entry_t    left_entry,
    input  wire pstq_pkg::entry_t    right_entry,
    input  wire                      prev_open,
    input  wire                      prev_gone,
    output pstq_pkg::entry_t         cur_entry,
    output pstq_pkg::entry_t         nxt_entry,
    output logic                     open,
    output logic                     gone
);
    import pstq_pkg::*;

    logic             valid_reg;
    logic [IdW-1:0]   id_reg;
    logic [PrioW-1:0] prio_reg;
    logic             match_reg;
    logic             open_reg;
    entry_t           entry_next;

    assign cur_entry = '{valid: valid_reg, id: id_reg, prio: prio_reg};
    assign open      = open_reg;
    // removal point at or before this cell
    assign gone      = prev_gone | match_reg;

    always_comb
    begin
        entry_next = cur_entry;
        if (ctl.do_ins)
        begin
            if (prev_open)
                entry_next = left_entry;
            else if (open_reg)
                entry_next = '{valid: 1'b1, id: ctl.id, prio: ctl.prio};
        end
        else if (ctl.do_rem && gone)
        begin
            entry_next = right_entry;
        end
    end

    assign nxt_entry = entry_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            match_reg <= 1'b0;
            open_reg  <= 1'b0;
        end
        else
        begin
            valid_reg <= entry_next.valid;
            if (ctl.cmp_en)
            begin
                match_reg <= valid_reg && (id_reg == ctl.id);
                open_reg  <= !valid_reg || (prio_reg < ctl.prio);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        id_reg   <= entry_next.id;
        prio_reg <= entry_next.prio;
    end

endmodule

`default_nettype wire

>>> rtl/priority_sorted_task_queue.sv
// Each accepted command passes compare, then apply (the shift through the cell
// chain), and its result beat is registered at apply. Apply waits while an
// earlier result is held by out_stall. No new command is taken until idle.
// Input beats are taken while an earlier result still waits at the output.
// Reset (rst_n, async, active low) empties the queue and clears all control;
// entry payload is not reset and is never read before it is written.
`default_nettype none

module priority_sorted_task_queue #(
    parameter int QUEUE_DEPTH = pstq_pkg::QueueDepthDefault
) (
    input  wire                        clk,
    input  wire                        rst_n,
    input  wire                        in_valid,
    output logic                       in_stall,
    input  wire  [pstq_pkg::CmdW-1:0]  command,
    input  wire  [pstq_pkg::IdW-1:0]   task_id,
    input  wire  [pstq_pkg::PrioW-1:0] priority_req,
    output logic                       out_valid,
    input  wire                        out_stall,
    output logic                       success,
    output logic [pstq_pkg::CntW-1:0]  count,
    output logic                       head_valid,
    output logic [pstq_pkg::IdW-1:0]   head_task
);
    import pstq_pkg::*;

    localparam int HeldW = $clog2(QUEUE_DEPTH + 1);

    // Sequencer: idle -> compare (cells latch match/open) -> apply (shift)
    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_CMP   = 3'b010,
        ST_APPLY = 3'b100
    } state_t;

    state_t           state_reg, state_next;
    logic [CmdW-1:0]  cmd_reg;
    logic [IdW-1:0]   id_reg;
    logic [PrioW-1:0] prio_reg;
    logic [HeldW-1:0] held_reg, held_next;

    logic             out_valid_reg;
    logic             success_reg;
    logic [CntW-1:0]  count_reg;
    logic             head_valid_reg;
    logic [IdW-1:0]   head_task_reg;

    cell_ctl_t        ctl;
    entry_t           cur_e   [QUEUE_DEPTH];
    entry_t           nxt_e   [QUEUE_DEPTH];
    logic             open_c  [QUEUE_DEPTH];
    logic             gone_c  [QUEUE_DEPTH];

    logic             in_take;
    logic             apply;
    logic             any_match;
    logic             full;
    logic             ok;
    logic [31:0]      held_wide;

    assign in_take   = in_valid && !in_stall;
    assign in_stall  = (state_reg != ST_IDLE);
    // apply only once the output register can take the result
    assign apply     = (state_reg == ST_APPLY) && (!out_valid_reg || !out_stall);
    // the gone chain ORs every match flag, so its tail says "id is held"
    assign any_match = gone_c[QUEUE_DEPTH-1];
    assign full      = cur_e[QUEUE_DEPTH-1].valid;

    always_comb
    begin
        ctl.cmp_en = (state_reg == ST_CMP);
        ctl.do_ins = apply && (cmd_reg == CMD_INSERT) && !any_match && !full;
        ctl.do_rem = apply && (cmd_reg == CMD_REMOVE) && any_match;
        ctl.id     = id_reg;
        ctl.prio   = prio_reg;
    end

    always_comb
    begin
        case (cmd_reg)
            CMD_INSERT: ok = !any_match && !full;
            CMD_REMOVE: ok = any_match;
            CMD_LOOKUP: ok = any_match;
            default:    ok = 1'b0;
        endcase
    end

    always_comb
    begin
        held_next = held_reg;
        if (ctl.do_ins)
            held_next = held_reg + HeldW'(1);
        else if (ctl.do_rem)
            held_next = held_reg - HeldW'(1);
    end

    assign held_wide = 32'(held_next);

    // Cell chain: data flows right on insert, left on remove
    genvar gi;
    generate
        for (gi = 0; gi < QUEUE_DEPTH; gi++)
        begin : g_cell
            entry_t left_e;
            entry_t right_e;
            logic   p_open;
            logic   p_gone;

            if (gi == 0)
            begin : g_first
                assign left_e = '0;
                assign p_open = 1'b0;
                assign p_gone = 1'b0;
            end
            else
            begin : g_mid
                assign left_e = cur_e[gi-1];
                assign p_open = open_c[gi-1];
                assign p_gone = gone_c[gi-1];
            end

            if (gi == QUEUE_DEPTH - 1)
            begin : g_last
                assign right_e = '0;
            end
            else
            begin : g_inner
                assign right_e = cur_e[gi+1];
            end

            pstq_cell u_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .ctl         (ctl),
                .left_entry  (left_e),
                .right_entry (right_e),
                .prev_open   (p_open),
                .prev_gone   (p_gone),
                .cur_entry   (cur_e[gi]),
                .nxt_entry   (nxt_e[gi]),
                .open        (open_c[gi]),
                .gone        (gone_c[gi])
            );
        end
    endgenerate

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (in_take) state_next = ST_CMP;
            ST_CMP:   state_next = ST_APPLY;
            ST_APPLY: if (apply) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            held_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            held_reg  <= held_next;
            if (apply)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // command and result payload
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            cmd_reg  <= command;
            id_reg   <= task_id;
            prio_reg <= priority_req;
        end
        if (apply)
        begin
            success_reg    <= ok;
            count_reg      <= held_wide[CntW-1:0];
            head_valid_reg <= nxt_e[0].valid;
            head_task_reg  <= nxt_e[0].valid ? nxt_e[0].id : '0;
        end
    end

    assign out_valid  = out_valid_reg;
    assign success    = success_reg;
    assign count      = count_reg;
    assign head_valid = head_valid_reg;
    assign head_task  = head_task_reg;

endmodule

`default_nettype wire

>>> dv/priority_sorted_task_queue_tb.sv
`timescale 1ns / 100ps

module priority_sorted_task_queue_tb;
    import pstq_pkg::*;

    localparam int QUEUE_DEPTH = QueueDepthDefault;

    // Command code 3 is not decoded by the block: it is a no-op with success 0.
    localparam logic [CmdW-1:0] CMD_NOP = 2'd3;

    // Stop well past the slowest legal run: about 2100 beats, each through the
    // compare and apply states, plus sender gaps, receiver stall bursts and drain
    // pauses.
    localparam int CYCLE_LIMIT = 400_000;

    // Settle time after the last result.
    localparam int TAIL_CYCLES = 8;

    typedef struct packed {
        logic            success;
        logic [CntW-1:0] count;
        logic            head_valid;
        logic [IdW-1:0]  head_task;
    } queue_result_t;

    logic             clk;
    logic             rst_n;
    logic             in_valid;
    logic             in_stall;
    logic [CmdW-1:0]  command;
    logic [IdW-1:0]   task_id;
    logic [PrioW-1:0] priority_req;
    logic             out_valid;
    logic             out_stall;
    logic             success;
    logic [CntW-1:0]  count;
    logic             head_valid;
    logic [IdW-1:0]   head_task;

    priority_sorted_task_queue #(
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .command     (command),
        .task_id     (task_id),
        .priority_req(priority_req),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .success     (success),
        .count       (count),
        .head_valid  (head_valid),
        .head_task   (head_task)
    );

    // Shadow copy of the queue contents. The head is in slot 0, and slots are
    // kept in descending priority order.
    logic [IdW-1:0]   held_ids   [QUEUE_DEPTH];
    logic [PrioW-1:0] held_prios [QUEUE_DEPTH];
    int               held_total;

    // Results that are owed by the block, oldest first.
    queue_result_t    pending_results[$];
    queue_result_t    oldest_result;

    int               fault_count;
    int               cycle_count;

    // Idle controls. Both are cleared for the last stretch of traffic.
    bit               sender_gaps_on;
    bit               receiver_stalls_on;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Returns the slot that holds the given id, or -1 if the id is not held.
    function automatic int find_held_slot(logic [IdW-1:0] id);
        for (int i = 0; i < held_total; i++)
            if (held_ids[i] == id)
                return i;
        return -1;
    endfunction

    // Applies one command to the shadow queue and returns the result that the
    // block must give for it.
    function automatic queue_result_t run_queue_command(logic [CmdW-1:0]  cmd,
                                                        logic [IdW-1:0]   id,
                                                        logic [PrioW-1:0] prio);
        queue_result_t res;
        int            slot;
        int            pos;
        slot        = find_held_slot(id);
        res.success = 1'b0;
        case (cmd)
            CMD_INSERT:
            begin
                if (slot < 0 && held_total < QUEUE_DEPTH)
                begin
                    // Place the new id ahead of the first strictly lower priority.
                    // Ties go behind, so they keep arrival order.
                    pos = held_total;
                    for (int k = 0; k < held_total; k++)
                    begin
                        if (held_prios[k] < prio)
                        begin
                            pos = k;
                            break;
                        end
                    end
                    for (int k = held_total; k > pos; k--)
                    begin
                        held_ids[k]   = held_ids[k-1];
                        held_prios[k] = held_prios[k-1];
                    end
                    held_ids[pos]   = id;
                    held_prios[pos] = prio;
                    held_total++;
                    res.success = 1'b1;
                end
            end
            CMD_REMOVE:
            begin
                if (slot >= 0)
                begin
                    // Close the gap.
                    for (int k = slot; k + 1 < held_total; k++)
                    begin
                        held_ids[k]   = held_ids[k+1];
                        held_prios[k] = held_prios[k+1];
                    end
                    held_total--;
                    res.success = 1'b1;
                end
            end
            CMD_LOOKUP:
                res.success = (slot >= 0);
            default: ;
        endcase
        res.count      = held_total[CntW-1:0];
        res.head_valid = (held_total > 0);
        res.head_task  = (held_total > 0) ? held_ids[0] : '0;
        return res;
    endfunction

    // Sends one beat and holds it until the block accepts it. The task is
    // entered at a falling edge and returns at a falling edge. Sometimes it
    // leaves a random gap after the beat.
    task automatic send_beat(logic [CmdW-1:0] cmd, logic [IdW-1:0] id,
                             logic [PrioW-1:0] prio);
        in_valid     <= 1'b1;
        command      <= cmd;
        task_id      <= id;
        priority_req <= prio;
        do
            @(posedge clk);
        while (in_stall);
        pending_results.push_back(run_queue_command(cmd, id, prio));
        @(negedge clk);
        if (sender_gaps_on && $urandom_range(0, 7) == 0)
        begin
            // The payload is free to change while valid is low.
            in_valid     <= 1'b0;
            command      <= CmdW'($urandom);
            task_id      <= IdW'($urandom);
            priority_req <= PrioW'($urandom);
            repeat ($urandom_range(1, 18)) @(negedge clk);
        end
    endtask

    // Picks an id that is held most of the time, and a random id otherwise.
    function automatic logic [IdW-1:0] pick_known_id();
        if (held_total > 0 && $urandom_range(0, 4) != 0)
            return held_ids[$urandom_range(0, held_total - 1)];
        return IdW'($urandom_range(0, 39));
    endfunction

    // Stops sending until the block has returned every result that it owes.
    task automatic test_drain_pause();
        in_valid <= 1'b0;
        do
            @(negedge clk);
        while (pending_results.size() != 0);
    endtask

    // Cases for the empty queue, the extreme ids and priorities, priority ties,
    // duplicate inserts, the unused command, and priorities that are ignored.
    task automatic test_basic_commands();
        send_beat(CMD_LOOKUP, 8'h00, 8'h00);     // lookup on the empty queue
        send_beat(CMD_REMOVE, 8'h55, 8'hFF);     // remove of an absent id, empty queue
        send_beat(CMD_NOP,    8'hFF, 8'hFF);     // unused command code
        send_beat(CMD_INSERT, 8'hFF, 8'h00);     // lowest priority, largest id
        send_beat(CMD_INSERT, 8'h00, 8'hFF);     // new head
        send_beat(CMD_INSERT, 8'h80, 8'hFF);     // tie with the head, goes behind it
        send_beat(CMD_INSERT, 8'h00, 8'h10);     // duplicate id is refused
        send_beat(CMD_INSERT, 8'h40, 8'h00);     // tie at the tail
        send_beat(CMD_LOOKUP, 8'h80, 8'hAA);     // priority ignored on lookup
        send_beat(CMD_LOOKUP, 8'h7F, 8'h00);     // miss
        send_beat(CMD_NOP,    8'h80, 8'h55);     // no-op with a non-empty queue
        send_beat(CMD_REMOVE, 8'h00, 8'h33);     // remove the head, priority ignored
        send_beat(CMD_REMOVE, 8'h00, 8'h33);     // same id again, now absent
        send_beat(CMD_REMOVE, 8'h40, 8'h00);     // remove the tail
        send_beat(CMD_REMOVE, 8'hFF, 8'h00);
        send_beat(CMD_REMOVE, 8'h80, 8'h00);     // queue is empty again
        send_beat(CMD_LOOKUP, 8'hFF, 8'hFF);
    endtask

    // Fills the queue to the top, tries inserts on the full queue, and then
    // empties it again in random order.
    task automatic test_full_queue();
        logic [IdW-1:0] id;
        while (held_total < QUEUE_DEPTH)
        begin
            id = IdW'($urandom);
            if (find_held_slot(id) < 0)
                send_beat(CMD_INSERT, id, PrioW'($urandom_range(0, 7)));
        end
        do
            id = IdW'($urandom);
        while (find_held_slot(id) >= 0);
        send_beat(CMD_INSERT, id, 8'hFF);               // full queue, refused
        send_beat(CMD_INSERT, held_ids[0], 8'h00);      // full queue and a duplicate
        send_beat(CMD_LOOKUP, held_ids[QUEUE_DEPTH-1], 8'h00);
        send_beat(CMD_LOOKUP, id, 8'h00);
        while (held_total > 0)
            send_beat(CMD_REMOVE, held_ids[$urandom_range(0, held_total - 1)],
                      PrioW'($urandom));
        send_beat(CMD_REMOVE, id, 8'h00);
    endtask

    // Mostly well-formed traffic. Phases of 64 beats alternate between
    // mostly inserts (to reach the full queue) and mostly removes (to empty it).
    // A small id pool causes many duplicates and hits.
    task automatic test_random_traffic(int beats);
        int               pick;
        int               insert_pct;
        logic [CmdW-1:0]  cmd;
        logic [IdW-1:0]   id;
        logic [PrioW-1:0] prio;
        for (int n = 0; n < beats; n++)
        begin
            insert_pct = ((n / 64) % 2 == 0) ? 70 : 20;
            pick       = $urandom_range(0, 99);
            // Use low priorities often, so that ties come up.
            prio = ($urandom_range(0, 3) == 0) ? PrioW'($urandom_range(0, 3))
                                                : PrioW'($urandom);
            if (pick < 3)
            begin
                cmd = CMD_NOP;
                id  = IdW'($urandom);
            end
            else if (pick < 3 + insert_pct)
            begin
                cmd = CMD_INSERT;
                id  = ($urandom_range(0, 9) == 0) ? IdW'($urandom)
                                                  : IdW'($urandom_range(0, 39));
            end
            else if (pick < 85)
            begin
                cmd = CMD_REMOVE;
                id  = pick_known_id();
            end
            else
            begin
                cmd = CMD_LOOKUP;
                id  = pick_known_id();
            end
            send_beat(cmd, id, prio);
        end
    endtask

    // Receiver: random stall bursts, with stretches of no stall in between.
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (receiver_stalls_on && $urandom_range(0, 5) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 18)) @(negedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    // Check each result beat against the oldest expected result.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result beat with no command outstanding");
                fault_count++;
            end
            else
            begin
                oldest_result = pending_results.pop_front();
                if (success !== oldest_result.success)
                begin
                    $error("success: expected %0d, got %0d", oldest_result.success, success);
                    fault_count++;
                end
                if (count !== oldest_result.count)
                begin
                    $error("count: expected %0d, got %0d", oldest_result.count, count);
                    fault_count++;
                end
                if (head_valid !== oldest_result.head_valid)
                begin
                    $error("head_valid: expected %0d, got %0d",
                           oldest_result.head_valid, head_valid);
                    fault_count++;
                end
                if (head_task !== oldest_result.head_task)
                begin
                    $error("head_task: expected 0x%02h, got 0x%02h",
                           oldest_result.head_task, head_task);
                    fault_count++;
                end
            end
        end
    end

    // Watchdog.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("priority_sorted_task_queue_tb: done, errors");
            $finish;
        end
    end

    initial
    begin
        rst_n              = 1'b0;
        in_valid           = 1'b0;
        command            = '0;
        task_id            = '0;
        priority_req       = '0;
        held_total         = 0;
        fault_count        = 0;
        cycle_count        = 0;
        sender_gaps_on     = 1'b1;
        receiver_stalls_on = 1'b1;
        for (int i = 0; i < QUEUE_DEPTH; i++)
        begin
            held_ids[i]   = '0;
            held_prios[i] = '0;
        end

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_basic_commands();
        test_full_queue();
        test_random_traffic(700);
        test_drain_pause();
        test_random_traffic(700);
        test_drain_pause();

        // Last stretch: no gaps and no stalls, so beats go back to back.
        sender_gaps_on     = 1'b0;
        receiver_stalls_on = 1'b0;
        test_random_traffic(600);

        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (pending_results.size() != 0)
        begin
            $error("%0d expected results never arrived", pending_results.size());
            fault_count++;
        end

        if (fault_count == 0)
            $display("priority_sorted_task_queue_tb: done, clean");
        else
            $display("priority_sorted_task_queue_tb: done, errors");
        $finish;
    end

endmodule
